### rtl/core/xcfp_pkg.sv
package xcfp_pkg;

    localparam logic [7:0] START_REQ = 8'hFA;
    localparam logic [7:0] START_ANS = 8'hFD;
    localparam logic [7:0] MARK_REQ  = 8'hAF;
    localparam logic [7:0] MARK_ANS  = 8'hDF;

    localparam logic [7:0] LAST_HDR_COUNT = 8'd4;
    localparam logic [8:0] FRAME_OVERHEAD = 9'd8;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_HCHECK  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_FINAL   = 3'd4
    } phase_t;

    typedef struct packed {
        logic [3:0] msg_type;
        logic [3:0] vendor_id;
        logic [3:0] model_id;
        logic [3:0] dest_address;
        logic [7:0] command_code;
        logic [7:0] payload_len;
        logic [8:0] frame_len;
    } result_t;

    typedef struct packed {
        logic in_final;
        logic done;
    } parse_status_t;

    function automatic logic [7:0] start_byte(input logic mode);
        return mode ? START_ANS : START_REQ;
    endfunction

    function automatic logic [7:0] marker_byte(input logic mode);
        return mode ? MARK_ANS : MARK_REQ;
    endfunction

endpackage

### rtl/core/xcfp_in_stage.sv
module xcfp_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic [7:0] in_byte_next;

    always_comb begin
        s_ready       = !in_valid_reg || advance;
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
            if (s_valid) begin
                in_byte_next = s_rx_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        in_byte_reg <= in_byte_next;
    end

    assign byte_valid = in_valid_reg;
    assign byte_data  = in_byte_reg;

endmodule

### rtl/core/xcfp_parser.sv
module xcfp_parser (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   frame_mode,
    input  logic                   byte_en,
    input  logic [7:0]             byte_data,
    output xcfp_pkg::parse_status_t status,
    output xcfp_pkg::result_t       result
);

    xcfp_pkg::phase_t phase_reg;
    xcfp_pkg::phase_t phase_next;
    logic [7:0] count_reg;
    logic [7:0] count_next;
    logic [7:0] xor_reg;
    logic [7:0] xor_next;
    logic [7:0] len_reg;
    logic [7:0] len_next;
    logic [7:0] id_a_reg;
    logic [7:0] id_a_next;
    logic [7:0] id_b_reg;
    logic [7:0] id_b_next;
    logic [7:0] mark_reg;
    logic [7:0] mark_next;
    logic [7:0] first_reg;
    logic [7:0] first_next;
    logic       done;

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        xor_next   = xor_reg;
        len_next   = len_reg;
        id_a_next  = id_a_reg;
        id_b_next  = id_b_reg;
        mark_next  = mark_reg;
        first_next = first_reg;
        done       = 1'b0;
        if (byte_en) begin
            unique case (phase_reg)
                xcfp_pkg::PH_HEADER: begin
                    unique case (count_reg)
                        8'd0:    mark_next = byte_data;
                        8'd1:    id_a_next = byte_data;
                        8'd2:    id_b_next = byte_data;
                        xcfp_pkg::LAST_HDR_COUNT: begin
                            len_next   = byte_data;
                            phase_next = xcfp_pkg::PH_HCHECK;
                        end
                        default: ;
                    endcase
                    count_next = count_reg + 8'd1;
                    xor_next   = xor_reg ^ byte_data;
                end
                xcfp_pkg::PH_HCHECK: begin
                    if (xor_reg == byte_data &&
                        mark_reg == xcfp_pkg::marker_byte(frame_mode)) begin
                        xor_next   = 8'd0;
                        count_next = 8'd0;
                        first_next = 8'd0;
                        phase_next = (len_reg == 8'd0) ? xcfp_pkg::PH_FINAL
                                                       : xcfp_pkg::PH_PAYLOAD;
                    end else begin
                        phase_next = xcfp_pkg::PH_HUNT;
                    end
                end
                xcfp_pkg::PH_PAYLOAD: begin
                    if (count_reg == 8'd0) begin
                        first_next = byte_data;
                    end
                    if (count_reg + 8'd1 == len_reg) begin
                        phase_next = xcfp_pkg::PH_FINAL;
                    end
                    count_next = count_reg + 8'd1;
                    xor_next   = xor_reg ^ byte_data;
                end
                xcfp_pkg::PH_FINAL: begin
                    done       = (xor_reg == byte_data);
                    phase_next = xcfp_pkg::PH_HUNT;
                end
                default: begin
                    phase_next = xcfp_pkg::PH_HUNT;
                    if (byte_data == xcfp_pkg::start_byte(frame_mode)) begin
                        phase_next = xcfp_pkg::PH_HEADER;
                        count_next = 8'd0;
                        xor_next   = byte_data;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= xcfp_pkg::PH_HUNT;
        end else begin
            phase_reg <= phase_next;
        end
        count_reg <= count_next;
        xor_reg   <= xor_next;
        len_reg   <= len_next;
        id_a_reg  <= id_a_next;
        id_b_reg  <= id_b_next;
        mark_reg  <= mark_next;
        first_reg <= first_next;
    end

    assign status.in_final     = (phase_reg == xcfp_pkg::PH_FINAL);
    assign status.done         = done;
    assign result.msg_type     = id_a_reg[7:4];
    assign result.vendor_id    = id_a_reg[3:0];
    assign result.model_id     = id_b_reg[7:4];
    assign result.dest_address = id_b_reg[3:0];
    assign result.command_code = first_reg;
    assign result.payload_len  = len_reg;
    assign result.frame_len    = {1'b0, len_reg} + xcfp_pkg::FRAME_OVERHEAD;

endmodule

### rtl/core/xcfp_out_stage.sv
module xcfp_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  xcfp_pkg::result_t result,
    output logic              busy,
    output logic              m_valid,
    input  logic              m_ready,
    output xcfp_pkg::result_t m_result
);

    logic              out_valid_reg;
    logic              out_valid_next;
    xcfp_pkg::result_t out_data_reg;
    xcfp_pkg::result_t out_data_next;

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        if (load) begin
            out_valid_next = 1'b1;
            out_data_next  = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
    end

    assign busy     = out_valid_reg && !m_ready;
    assign m_valid  = out_valid_reg;
    assign m_result = out_data_reg;

endmodule

### rtl/core/xor_checked_frame_parser_core.sv
// XOR-checked frame parser core.
// The input channel (s_valid, s_ready, s_rx_byte) takes one received byte per
// request. The parser hunts for the start byte of the selected mode, checks the
// header checksum and marker, walks the payload and checks the final XOR. Each
// good frame gives one request on the result channel (m_valid, m_ready and the
// m_ fields); a failed frame gives nothing and the parser goes back to hunting.
// A byte is accepted into the input register and parsed from there; parsing a
// good final checksum byte loads the output register at the same edge, and the
// result is then offered on the result channel from the output register.
// The block takes one byte per cycle unless a final checksum byte waits (see below);
// the running XOR and the short state update between the input register and the state registers set that rate.
// While a result waits on the output register, bytes keep being accepted; only
// a final checksum byte waits in the input register until the output register
// is free. cfg_wr_en writes frame_mode from cfg_wr_data, 0 for request frames
// and 1 for answer frames; write it only while the block is idle.
// Reset clears the mode to request frames, empties both registers and puts the
// parser into hunting.
module xor_checked_frame_parser_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_msg_type,
    output logic [3:0] m_vendor_id,
    output logic [3:0] m_model_id,
    output logic [3:0] m_dest_address,
    output logic [7:0] m_command_code,
    output logic [7:0] m_payload_len,
    output logic [8:0] m_frame_len
);

    logic                    mode_reg;
    logic                    mode_next;
    logic                    byte_valid;
    logic [7:0]              byte_data;
    logic                    advance;
    logic                    out_busy;
    xcfp_pkg::parse_status_t status;
    xcfp_pkg::result_t       result;
    xcfp_pkg::result_t       m_result;

    assign mode_next = cfg_wr_en ? cfg_wr_data : mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else begin
            mode_reg <= mode_next;
        end
    end

    assign advance = byte_valid && !(status.in_final && out_busy);

    xcfp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    xcfp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .frame_mode (mode_reg),
        .byte_en    (advance),
        .byte_data  (byte_data),
        .status     (status),
        .result     (result)
    );

    xcfp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (status.done),
        .result   (result),
        .busy     (out_busy),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_msg_type     = m_result.msg_type;
    assign m_vendor_id    = m_result.vendor_id;
    assign m_model_id     = m_result.model_id;
    assign m_dest_address = m_result.dest_address;
    assign m_command_code = m_result.command_code;
    assign m_payload_len  = m_result.payload_len;
    assign m_frame_len    = m_result.frame_len;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int RANDOM_ITEMS  = 850;
    localparam int RANDOM_PHASES = 4;
    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DIR_ROWS      = 25;

    typedef struct packed {
        logic              set_mode;
        logic [7:0]        value;
        logic              typed;
        xcfp_pkg::result_t want;
    } dir_row_t;

    localparam xcfp_pkg::result_t NO_FRAME = '0;

    logic       aclk;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte   = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [3:0] m_msg_type;
    logic [3:0] m_vendor_id;
    logic [3:0] m_model_id;
    logic [3:0] m_dest_address;
    logic [7:0] m_command_code;
    logic [7:0] m_payload_len;
    logic [8:0] m_frame_len;

    // Side band held with each directed request; a typed row supplies its own result.
    logic              dir_typed = 1'b0;
    xcfp_pkg::result_t dir_want  = '0;

    // Parser copy kept by the testbench.
    xcfp_pkg::phase_t parse_phase;
    logic       mode_shadow;
    logic [7:0] hdr_count;
    logic [7:0] xor_acc;
    logic [7:0] len_hold;
    logic [7:0] id_hi;
    logic [7:0] id_lo;
    logic [7:0] marker_got;
    logic [7:0] cmd_first;

    xcfp_pkg::result_t pending_frames [$];
    xcfp_pkg::result_t got_frame;
    xcfp_pkg::result_t calc_frame;
    bit         calc_has;

    int         bytes_accepted;
    int         frame_bytes;
    int         frames_checked;
    int         mismatches;
    int         burst_left;
    int         idle_cycles;
    logic [15:0] ready_pattern = '1;
    logic [15:0] ready_step    = '0;

    dir_row_t dir_table [DIR_ROWS] = '{
        // Request frame right after reset, empty payload, all-ones and all-zeros ids.
        '{1'b0, 8'hFA, 1'b0, NO_FRAME},
        '{1'b0, 8'hAF, 1'b0, NO_FRAME},
        '{1'b0, 8'hFF, 1'b0, NO_FRAME},
        '{1'b0, 8'h00, 1'b0, NO_FRAME},
        '{1'b0, 8'h00, 1'b0, NO_FRAME},
        '{1'b0, 8'h00, 1'b0, NO_FRAME},
        '{1'b0, 8'hAA, 1'b0, NO_FRAME},
        '{1'b0, 8'h00, 1'b1, '{4'hF, 4'hF, 4'h0, 4'h0, 8'h00, 8'h00, 9'd8}},
        '{1'b1, 8'h01, 1'b0, NO_FRAME},
        // Answer frame with a one-byte payload.
        '{1'b0, 8'hFD, 1'b0, NO_FRAME},
        '{1'b0, 8'hDF, 1'b0, NO_FRAME},
        '{1'b0, 8'h00, 1'b0, NO_FRAME},
        '{1'b0, 8'hFF, 1'b0, NO_FRAME},
        '{1'b0, 8'h00, 1'b0, NO_FRAME},
        '{1'b0, 8'h01, 1'b0, NO_FRAME},
        '{1'b0, 8'hDC, 1'b0, NO_FRAME},
        '{1'b0, 8'hFF, 1'b0, NO_FRAME},
        '{1'b0, 8'hFF, 1'b1, '{4'h0, 4'h0, 4'hF, 4'hF, 8'hFF, 8'h01, 9'd9}},
        // Request marker in answer mode and a bad header checksum that is a start byte.
        '{1'b0, 8'hFD, 1'b0, NO_FRAME},
        '{1'b0, 8'hAF, 1'b0, NO_FRAME},
        '{1'b0, 8'h12, 1'b0, NO_FRAME},
        '{1'b0, 8'h34, 1'b0, NO_FRAME},
        '{1'b0, 8'h00, 1'b0, NO_FRAME},
        '{1'b0, 8'h00, 1'b0, NO_FRAME},
        '{1'b0, 8'hFD, 1'b0, NO_FRAME}
    };

    xor_checked_frame_parser_core i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_msg_type     (m_msg_type),
        .m_vendor_id    (m_vendor_id),
        .m_model_id     (m_model_id),
        .m_dest_address (m_dest_address),
        .m_command_code (m_command_code),
        .m_payload_len  (m_payload_len),
        .m_frame_len    (m_frame_len)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic bit parse_byte(input logic [7:0] c, output xcfp_pkg::result_t r);
        bit has;
        has = 1'b0;
        r = '0;
        case (parse_phase)
            xcfp_pkg::PH_HEADER: begin
                if (hdr_count == 8'd0) marker_got = c;
                else if (hdr_count == 8'd1) id_hi = c;
                else if (hdr_count == 8'd2) id_lo = c;
                else if (hdr_count == xcfp_pkg::LAST_HDR_COUNT) len_hold = c;
                if (hdr_count == xcfp_pkg::LAST_HDR_COUNT) parse_phase = xcfp_pkg::PH_HCHECK;
                hdr_count = hdr_count + 8'd1;
                xor_acc = xor_acc ^ c;
            end
            xcfp_pkg::PH_HCHECK: begin
                if (xor_acc == c &&
                    marker_got == (mode_shadow ? xcfp_pkg::MARK_ANS : xcfp_pkg::MARK_REQ)) begin
                    xor_acc = '0;
                    hdr_count = '0;
                    cmd_first = '0;
                    parse_phase = (len_hold == 8'd0) ? xcfp_pkg::PH_FINAL
                                                     : xcfp_pkg::PH_PAYLOAD;
                end else begin
                    parse_phase = xcfp_pkg::PH_HUNT;
                end
            end
            xcfp_pkg::PH_PAYLOAD: begin
                if (hdr_count == 8'd0) cmd_first = c;
                if (8'(hdr_count + 8'd1) == len_hold) parse_phase = xcfp_pkg::PH_FINAL;
                hdr_count = hdr_count + 8'd1;
                xor_acc = xor_acc ^ c;
            end
            xcfp_pkg::PH_FINAL: begin
                if (xor_acc == c) begin
                    r = '{id_hi[7:4], id_hi[3:0], id_lo[7:4], id_lo[3:0], cmd_first, len_hold,
                          {1'b0, len_hold} + xcfp_pkg::FRAME_OVERHEAD};
                    has = 1'b1;
                end
                parse_phase = xcfp_pkg::PH_HUNT;
            end
            default: begin
                parse_phase = xcfp_pkg::PH_HUNT;
                if (c == (mode_shadow ? xcfp_pkg::START_ANS : xcfp_pkg::START_REQ)) begin
                    parse_phase = xcfp_pkg::PH_HEADER;
                    hdr_count = '0;
                    xor_acc = c;
                end
            end
        endcase
        return has;
    endfunction

    function automatic string frame_text(input xcfp_pkg::result_t r);
        return $sformatf("type %h vendor %h model %h dest %h cmd %h len %0d frame %0d",
                         r.msg_type, r.vendor_id, r.model_id, r.dest_address,
                         r.command_code, r.payload_len, r.frame_len);
    endfunction

    task automatic note_error(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("[%0t] ERROR: %s", $time, msg);
    endtask

    task automatic check_frame(input xcfp_pkg::result_t got);
        xcfp_pkg::result_t want;
        if (pending_frames.size() == 0) begin
            note_error({"unexpected frame: ", frame_text(got)});
            return;
        end
        want = pending_frames.pop_front();
        frames_checked++;
        if (got.msg_type !== want.msg_type || got.vendor_id !== want.vendor_id ||
            got.model_id !== want.model_id || got.dest_address !== want.dest_address ||
            got.command_code !== want.command_code || got.payload_len !== want.payload_len ||
            got.frame_len !== want.frame_len) begin
            note_error({"frame mismatch, expected ", frame_text(want),
                        " got ", frame_text(got)});
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            parse_phase = xcfp_pkg::PH_HUNT;
            mode_shadow = 1'b0;
            hdr_count   = '0;
            xor_acc     = '0;
            len_hold    = '0;
            id_hi       = '0;
            id_lo       = '0;
            marker_got  = '0;
            cmd_first   = '0;
        end else begin
            if (cfg_wr_en) mode_shadow = cfg_wr_data;
            if (m_valid && m_ready) begin
                got_frame = '{m_msg_type, m_vendor_id, m_model_id, m_dest_address,
                              m_command_code, m_payload_len, m_frame_len};
                check_frame(got_frame);
            end
            if (s_valid && s_ready) begin
                bytes_accepted++;
                calc_has = parse_byte(s_rx_byte, calc_frame);
                if (dir_typed) pending_frames.push_back(dir_want);
                else if (calc_has) pending_frames.push_back(calc_frame);
            end
        end
    end

    always @(posedge aclk) begin
        ready_step <= ready_step + 16'd1;
        if (ready_step[5:0] == 6'd0) begin
            ready_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        end
        m_ready <= ready_pattern[ready_step[3:0]];
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Watchdog: no request moved for %0d cycles.", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (pending_frames.size() != 0);
    endtask

    task automatic set_frame_mode(input logic mode);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_frame(input logic mode, input int plen);
        logic [7:0] bytes [$];
        logic [7:0] acc;
        logic [7:0] b;
        int         flaw;
        int         keep;
        flaw = $urandom_range(0, 9);
        bytes.push_back(mode ? xcfp_pkg::START_ANS : xcfp_pkg::START_REQ);
        if (flaw == 1) begin
            bytes.push_back(($urandom_range(0, 1) == 0)
                            ? (mode ? xcfp_pkg::MARK_REQ : xcfp_pkg::MARK_ANS)
                            : 8'($urandom));
        end else begin
            bytes.push_back(mode ? xcfp_pkg::MARK_ANS : xcfp_pkg::MARK_REQ);
        end
        repeat (3) bytes.push_back(8'($urandom));
        bytes.push_back(plen[7:0]);
        acc = '0;
        foreach (bytes[i]) acc ^= bytes[i];
        bytes.push_back(acc);
        acc = '0;
        for (int i = 0; i < plen; i++) begin
            b = 8'($urandom);
            acc ^= b;
            bytes.push_back(b);
        end
        bytes.push_back(acc);
        if (flaw == 0) begin
            b = 8'(1 << $urandom_range(0, 7));
            bytes[$urandom_range(0, bytes.size() - 1)] ^= b;
        end else if (flaw == 2) begin
            keep = $urandom_range(1, bytes.size() - 1);
            while (bytes.size() > keep) void'(bytes.pop_back());
        end
        foreach (bytes[i]) send_byte(bytes[i]);
        frame_bytes += bytes.size();
    endtask

    initial begin
        int r;
        int plen;
        int phase_start;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_table[i].set_mode) begin
                set_frame_mode(dir_table[i].value[0]);
            end else begin
                dir_typed <= dir_table[i].typed;
                dir_want  <= dir_table[i].want;
                send_byte(dir_table[i].value);
            end
        end
        dir_typed <= 1'b0;

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_frame_mode(p[0]);
            phase_start = frame_bytes;
            // One frame with the longest payload, which also gives the longest frame length.
            if (p == 1) send_frame(1'b1, 255);
            while (frame_bytes - phase_start < RANDOM_ITEMS / RANDOM_PHASES) begin
                if ($urandom_range(0, 5) == 0) begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
                end
                r = $urandom_range(0, 99);
                if (r == 0) plen = $urandom_range(128, 255);
                else if (r < 6) plen = $urandom_range(7, 40);
                else plen = $urandom_range(0, 6);
                send_frame(p[0], plen);
                if ($urandom_range(0, 14) == 0) drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES + 2) @(posedge aclk);

        $display("Sent %0d bytes as request and answer frames, clean and damaged.",
                 bytes_accepted);
        $display("Checked %0d parsed frames; %0d mismatches found.", frames_checked, mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
